// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// SCD_ASSERT_IMP checks a same-cycle implication and SCD_ASSERT_NXT checks
// an implication in the next cycle. Both are empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/scd_pkg.sv -----
// ---------------------------------------------------------------------------
// scd_pkg
// Types, byte codes and character tables of the scan code decoder.
// ---------------------------------------------------------------------------
package scd_pkg;

    typedef logic [7:0]        t_scan;
    typedef logic signed [8:0] t_char;

    typedef struct packed {
        logic lshift;
        logic rshift;
        logic caps;
        logic num;
        logic accent;
        logic ext;
    } t_flags;

    localparam int TableEntries = 83;
    localparam int TableRom     = 83;
    localparam int RomLimit     = (TableEntries < TableRom) ? TableEntries : TableRom;
    localparam int KeypadDepth  = 13;

    localparam t_scan ExtPrefix   = 8'hE0;
    localparam t_scan LshiftBreak = 8'd170;
    localparam t_scan RshiftBreak = 8'd182;
    localparam t_scan AccentKey   = 8'd40;
    localparam t_scan LshiftMake  = 8'd42;
    localparam t_scan RshiftMake  = 8'd54;
    localparam t_scan CapsKey     = 8'd58;
    localparam t_scan NumKey      = 8'd69;
    localparam t_scan MakeLimit   = 8'd128;
    localparam t_scan KeypadFirst = 8'd71;

    localparam t_char NoChar   = -9'sd1;
    localparam t_char NonPrint = -9'sd5;

    localparam t_char PlainRom [TableRom] = '{
        -9'sd1,  9'sd49,  9'sd50,  9'sd51,  9'sd52,  9'sd53,  9'sd54,  9'sd55,
         9'sd56,  9'sd57,  9'sd48,  9'sd39, 9'sd168,   9'sd8,   9'sd9, 9'sd113,
        9'sd119, 9'sd101, 9'sd114, 9'sd116, 9'sd121, 9'sd117, 9'sd105, 9'sd111,
        9'sd112, 9'sd123,  9'sd43,  9'sd10,  -9'sd5,  9'sd97, 9'sd115, 9'sd100,
        9'sd102, 9'sd103, 9'sd104, 9'sd106, 9'sd107, 9'sd108, 9'sd164,  -9'sd5,
        9'sd125, 9'sd124,  -9'sd5, 9'sd122, 9'sd120,  9'sd99, 9'sd118,  9'sd98,
        9'sd110, 9'sd109,  9'sd44,  9'sd46,  9'sd45,  -9'sd5,  -9'sd5,  -9'sd5,
         9'sd32,  -9'sd5,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  9'sd78,  9'sd83,  9'sd72, 9'sd202,
         -9'sd1,  9'sd45, 9'sd185, 9'sd206, 9'sd204,  9'sd43,  9'sd69, 9'sd203,
         -9'sd1,  9'sd73,  9'sd68
    };

    localparam t_char ShiftedRom [TableRom] = '{
        -9'sd1,  9'sd33,  9'sd34,  9'sd35,  9'sd36,  9'sd37,  9'sd38,  9'sd47,
         9'sd40,  9'sd41,  9'sd61,  9'sd63, 9'sd173,   9'sd8,   9'sd9,  9'sd81,
         9'sd87,  9'sd69,  9'sd82,  9'sd84,  9'sd89,  9'sd85,  9'sd73,  9'sd79,
         9'sd80,  9'sd91,  9'sd42,  9'sd10,  -9'sd5,  9'sd65,  9'sd83,  9'sd68,
         9'sd70,  9'sd71,  9'sd72,  9'sd74,  9'sd75,  9'sd76, 9'sd165,  -9'sd5,
         9'sd93, 9'sd167,  -9'sd5,  9'sd90,  9'sd88,  9'sd67,  9'sd86,  9'sd66,
         9'sd78,  9'sd77,  9'sd59,  9'sd58,  9'sd95,  -9'sd5,  -9'sd5,  -9'sd5,
         9'sd32,  -9'sd5,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  9'sd78,  9'sd83,  9'sd72, 9'sd202,
         -9'sd1,  9'sd45, 9'sd185, 9'sd206, 9'sd204,  9'sd43,  9'sd69, 9'sd203,
         -9'sd1,  9'sd73,  9'sd68
    };

    localparam t_char ExtRom [TableRom] = '{
        -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  9'sd10,  -9'sd5,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd5,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,
         -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  -9'sd1,  9'sd72, 9'sd202,
         -9'sd1,  9'sd45, 9'sd185, 9'sd206, 9'sd204,  -9'sd1,  9'sd69, 9'sd203,
         -9'sd1,  9'sd73,  9'sd68
    };

    localparam t_char KeypadRom [KeypadDepth] = '{
        9'sd55, 9'sd56, 9'sd57, -9'sd1, 9'sd52, 9'sd53, 9'sd54, -9'sd1,
        9'sd49, 9'sd50, 9'sd51, 9'sd48, 9'sd46
    };

endpackage

// ----- hw/rtl/scd_decode.sv -----
// ---------------------------------------------------------------------------
// scd_decode
// Single-pass lookup of one scan byte: character code and next key flags.
// ---------------------------------------------------------------------------
module scd_decode (
    input  scd_pkg::t_scan  i_scan,
    input  scd_pkg::t_flags i_flags,
    output scd_pkg::t_char  o_char,
    output scd_pkg::t_flags o_flags
);

    logic           rom_hit;
    logic [6:0]     rom_idx;
    logic [3:0]     kp_idx;
    logic [7:0]     kp_off;
    scd_pkg::t_char plain_c;
    scd_pkg::t_char shift_c;
    scd_pkg::t_char ext_c;
    scd_pkg::t_char kp_c;
    scd_pkg::t_char acc_c;
    logic           letter;
    logic           keypad;
    logic           shifted;

    // Codes outside the tables read as no character
    assign rom_hit = (i_scan != 8'd0) && ({24'd0, i_scan} <= 32'(scd_pkg::RomLimit));
    assign rom_idx = rom_hit ? 7'(i_scan - 8'd1) : 7'd0;

    assign plain_c = rom_hit ? scd_pkg::PlainRom[rom_idx]   : scd_pkg::NoChar;
    assign shift_c = rom_hit ? scd_pkg::ShiftedRom[rom_idx] : scd_pkg::NoChar;
    assign ext_c   = rom_hit ? scd_pkg::ExtRom[rom_idx]     : scd_pkg::NoChar;

    assign keypad = ((i_scan >= 8'd71) && (i_scan <= 8'd73)) ||
                    ((i_scan >= 8'd75) && (i_scan <= 8'd77)) ||
                    ((i_scan >= 8'd79) && (i_scan <= 8'd83));
    assign kp_off = i_scan - scd_pkg::KeypadFirst;
    assign kp_idx = keypad ? kp_off[3:0] : 4'd0;
    assign kp_c   = scd_pkg::KeypadRom[kp_idx];

    assign letter  = ((plain_c >= 9'sd97) && (plain_c <= 9'sd122)) || (plain_c == 9'sd164);
    assign shifted = i_flags.lshift || i_flags.rshift;

    always_comb begin
        if (i_flags.caps || shifted) begin
            acc_c = scd_pkg::NoChar;
        end else begin
            unique case (plain_c)
                9'sd97:  acc_c = 9'sd160;
                9'sd101: acc_c = 9'sd130;
                9'sd105: acc_c = 9'sd161;
                9'sd111: acc_c = 9'sd162;
                9'sd117: acc_c = 9'sd163;
                default: acc_c = scd_pkg::NoChar;
            endcase
        end
    end

    always_comb begin
        o_flags = i_flags;
        o_char  = scd_pkg::NoChar;
        priority if (i_scan == scd_pkg::ExtPrefix) begin
            o_flags.ext = 1'b1;
        end else if (i_scan == scd_pkg::LshiftBreak) begin
            o_flags.lshift = 1'b0;
        end else if (i_scan == scd_pkg::RshiftBreak) begin
            o_flags.rshift = 1'b0;
        end else if (i_scan <= scd_pkg::MakeLimit) begin
            priority if (i_flags.accent) begin
                o_flags.accent = 1'b0;
                o_char         = acc_c;
            end else if (i_flags.ext) begin
                o_flags.ext = 1'b0;
                o_char      = ext_c;
            end else if (i_scan == scd_pkg::AccentKey) begin
                o_flags.accent = 1'b1;
            end else if (i_scan == scd_pkg::LshiftMake) begin
                o_flags.lshift = 1'b1;
            end else if (i_scan == scd_pkg::RshiftMake) begin
                o_flags.rshift = 1'b1;
            end else if (i_scan == scd_pkg::CapsKey) begin
                o_flags.caps = !i_flags.caps;
            end else if (i_scan == scd_pkg::NumKey) begin
                o_flags.num = !i_flags.num;
            end else if (i_flags.caps && letter) begin
                o_char = shifted ? plain_c : shift_c;
            end else if ((shifted || i_flags.num) && keypad) begin
                o_char = kp_c;
            end else if (shifted) begin
                o_char = shift_c;
            end else begin
                o_char = plain_c;
            end
        end else begin
            // drop any other break code: no character, flags held
            o_char = scd_pkg::NoChar;
        end
    end

endmodule

// ----- hw/rtl/scancode_to_ascii_decoder.sv -----
// ---------------------------------------------------------------------------
// scancode_to_ascii_decoder
// Set-1 keyboard scan byte to character code, one beat in, one beat out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_scan_valid / o_scan_ready carry one raw scan byte per
//   beat on i_scan_byte. Output channel: o_char_valid / i_char_ready carry
//   one 9-bit signed character code per beat on o_char_code; -1 means no
//   character, -5 a non-printing key.
//   Every input beat yields exactly one output beat, in order.
//   A byte accepted into the input register moves into the result register,
//   and so onto o_char_code, when the output is not stalled.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the single lookup between the input register and the result register.
//   Key flags (shifts, caps lock, num lock, accent, extended prefix) update
//   as each byte moves into the result register, so they follow byte order.
//   Reset (synchronous, active low) clears all flags and both valid bits.
//   When the receiver stalls, the result register holds its beat and the
//   input register holds one more; o_scan_ready then drops until the
//   output beat is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scancode_to_ascii_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_scan_valid,
    output logic                o_scan_ready,
    input  scd_pkg::t_scan      i_scan_byte,
    output logic                o_char_valid,
    input  logic                i_char_ready,
    output scd_pkg::t_char      o_char_code
);

    logic            r_in_valid;
    scd_pkg::t_scan  r_scan;
    logic            r_out_valid;
    scd_pkg::t_char  r_char;
    scd_pkg::t_flags r_flags;

    scd_pkg::t_char  n_char;
    scd_pkg::t_flags n_flags;
    logic            advance;

    // Move the held byte on whenever the result register is free or draining
    assign advance      = r_in_valid && (!r_out_valid || i_char_ready);
    assign o_scan_ready = !r_in_valid || advance;

    scd_decode u_decode (
        .i_scan  (r_scan),
        .i_flags (r_flags),
        .o_char  (n_char),
        .o_flags (n_flags)
    );

    // Input register: take a new byte whenever it is empty or the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_scan_ready) begin
            r_in_valid <= i_scan_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_scan_ready && i_scan_valid) begin
            r_scan <= i_scan_byte;
        end
    end

    // Flags advance with the byte that leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (advance) begin
            r_flags <= n_flags;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_char_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char <= n_char;
        end
    end

    assign o_char_valid = r_out_valid;
    assign o_char_code  = r_char;

    `SCD_ASSERT_NXT(a_ext_set, i_clk, i_rst_n, advance && (r_scan == scd_pkg::ExtPrefix), r_flags.ext)
    `SCD_ASSERT_NXT(a_break_keeps_flags, i_clk, i_rst_n, advance && (r_scan > scd_pkg::MakeLimit) && (r_scan != scd_pkg::ExtPrefix) && (r_scan != scd_pkg::LshiftBreak) && (r_scan != scd_pkg::RshiftBreak), $stable(r_flags))
    `SCD_ASSERT_IMP(a_neg_codes, i_clk, i_rst_n, o_char_valid && o_char_code[8], (o_char_code == scd_pkg::NoChar) || (o_char_code == scd_pkg::NonPrint))
    `SCD_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, o_scan_ready)

endmodule
